// ===== hdl/assert_macros.svh =====
// assertion macros shared by the pin change reporter modules
// expects clk and rst (synchronous, active high) in the using scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent must hold at the edge that follows the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/pcr_pkg.sv =====
// shared types and constants for the pin change reporter
// no dependencies
`timescale 1ns / 1ps

package pcr_pkg;

  localparam int NUM_PINS    = 16;
  localparam int PIN_IDX_W   = $clog2(NUM_PINS);
  localparam int PIN_W       = 4;
  localparam int SAMPLE_W    = 10;
  localparam int MODE_W      = 2;
  localparam int MODES_W     = 32;
  localparam int BYTE_W      = 8;
  localparam int SLOT_W      = 4;
  localparam int COUNT_W     = 5;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [MODE_W-1:0]  MODE_DIN    = 2'd0;
  localparam logic [MODE_W-1:0]  MODE_ADC    = 2'd2;
  localparam logic [PIN_W-1:0]   SKIPPED_PIN = 4'd3;
  localparam logic [COUNT_W-1:0] FRAME_MAX   = 5'd16;

  // one classified item between front and back
  typedef struct packed {
    logic               have_rec;
    logic [PIN_W-1:0]   pin;
    logic [MODE_W-1:0]  mode;
    logic [BYTE_W-1:0]  value_high;
    logic [BYTE_W-1:0]  value_low;
    logic [SLOT_W-1:0]  slot;
    logic               close;
    logic [COUNT_W-1:0] count;
  } entry_t;

  // one output beat
  typedef struct packed {
    logic               frame_close;
    logic [PIN_W-1:0]   rec_pin;
    logic [MODE_W-1:0]  rec_mode;
    logic [BYTE_W-1:0]  value_high;
    logic [BYTE_W-1:0]  value_low;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] record_count;
    logic               last;
  } result_t;

endpackage

// ===== hdl/pcr_front.sv =====
// front end: mode register, per-pin change detection and frame count
// depends on pcr_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pcr_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pin_modes_we,
  input  logic [pcr_pkg::MODES_W-1:0]   pin_modes,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pcr_pkg::PIN_W-1:0]     pin,
  input  logic [pcr_pkg::SAMPLE_W-1:0]  sample,
  input  logic                          scan_end,
  input  logic                          q_full,
  output logic                          push,
  output pcr_pkg::entry_t               entry
);
  import pcr_pkg::*;

  logic [MODES_W-1:0]   modes;
  logic [SAMPLE_W-1:0]  last_reported [NUM_PINS];
  logic [COUNT_W-1:0]   frame_records;
  logic [COUNT_W-1:0]   frame_records_next;

  logic [PIN_IDX_W-1:0] idx;
  logic [MODE_W-1:0]    mode;
  logic                 in_range;
  logic                 watched;
  logic [SAMPLE_W-1:0]  val;
  logic                 changed;
  logic [COUNT_W-1:0]   count_after;
  logic                 close;
  logic                 accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign idx      = PIN_IDX_W'(pin);
  assign in_range = (32'(pin) < NUM_PINS);
  assign mode     = modes[{idx, 1'b0} +: MODE_W];
  assign watched  = in_range && (pin != SKIPPED_PIN) &&
                    ((mode == MODE_DIN) || (mode == MODE_ADC));
  assign val      = (mode == MODE_DIN) ? {{(SAMPLE_W-1){1'b0}}, sample[0]} : sample;
  assign changed  = watched && (last_reported[idx] != val) && (frame_records < FRAME_MAX);

  assign count_after = frame_records + COUNT_W'(changed);
  assign close       = scan_end && (count_after != '0);
  assign frame_records_next = close ? '0 : count_after;

  assign push = accept && (changed || close);

  always_comb begin
    entry.have_rec = changed;
    entry.pin      = pin;
    entry.mode     = mode;
    if (mode == MODE_DIN) begin
      entry.value_high = {{(BYTE_W-1){1'b0}}, sample[0]};
      entry.value_low  = '0;
    end else begin
      entry.value_high = BYTE_W'(sample[SAMPLE_W-1:BYTE_W]);
      entry.value_low  = sample[BYTE_W-1:0];
    end
    entry.slot  = frame_records[SLOT_W-1:0];
    entry.close = close;
    entry.count = count_after;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modes         <= '0;
      frame_records <= '0;
      for (int i = 0; i < NUM_PINS; i++) begin
        last_reported[i] <= '0;
      end
    end else begin
      if (pin_modes_we) begin
        modes <= pin_modes;
      end
      if (accept) begin
        frame_records <= frame_records_next;
        if (changed) begin
          last_reported[idx] <= val;
        end
      end
    end
  end

  `ASSERT_ALWAYS(a_frame_bound, frame_records <= FRAME_MAX, "frame count above limit")
  `ASSERT_NEXT(a_close_clears, push && entry.close, frame_records == '0,
               "frame count not cleared after close")

endmodule

// ===== hdl/pcr_queue.sv =====
// short queue of classified items between front and back
// depends on pcr_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pcr_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  pcr_pkg::entry_t  wr_entry,
  input  logic             pop,
  output pcr_pkg::entry_t  head,
  output logic             full,
  output logic             empty
);
  import pcr_pkg::*;

  entry_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  `ASSERT_ALWAYS(a_no_overflow, !(push && full), "push into full queue")

endmodule

// ===== hdl/pcr_back.sv =====
// back end: expands queued items into record and frame-close beats
// depends on pcr_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pcr_back (
  input  logic             clk,
  input  logic             rst,
  input  pcr_pkg::entry_t  head,
  input  logic             empty,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output pcr_pkg::result_t out_beat
);
  import pcr_pkg::*;

  logic    phase;
  logic    phase_next;
  logic    load;
  logic    rec_beat;
  result_t beat_next;

  assign load     = !empty && (!out_valid || out_ready);
  assign rec_beat = head.have_rec && !phase;
  assign pop      = load && !(rec_beat && head.close);

  always_comb begin
    phase_next = phase;
    if (load) begin
      phase_next = rec_beat && head.close;
    end
  end

  always_comb begin
    beat_next = '0;
    if (rec_beat) begin
      beat_next.rec_pin    = head.pin;
      beat_next.rec_mode   = head.mode;
      beat_next.value_high = head.value_high;
      beat_next.value_low  = head.value_low;
      beat_next.slot       = head.slot;
      beat_next.last       = !head.close;
    end else begin
      beat_next.frame_close  = 1'b1;
      beat_next.record_count = head.count;
      beat_next.last         = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      phase <= phase_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_beat <= beat_next;
    end
  end

  `ASSERT_ALWAYS(a_phase_close, !phase || (!empty && head.close),
                 "second beat pending without a close")

endmodule

// ===== hdl/pin_change_reporter_unit.sv =====
// top level of the pin change reporter
// depends on pcr_pkg, pcr_front, pcr_queue and pcr_back
//
//   channel   handshake                 payload
//   in        in_valid / in_ready       pin, sample, scan_end
//   out       out_valid / out_ready     frame_close .. last
//   config    pin_modes_we              pin_modes
//
// one input beat per cycle while the four-entry queue has room
// an item with a record and a frame close gives a record beat, then a frame-close beat
// an item passes through the queue memory and then the output beat register
// synchronous reset clears modes, stored values, frame count and queue
// output stalls back up through the queue to in_ready
`timescale 1ns / 1ps

module pin_change_reporter_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pin_modes_we,
  input  logic [pcr_pkg::MODES_W-1:0]   pin_modes,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pcr_pkg::PIN_W-1:0]     pin,
  input  logic [pcr_pkg::SAMPLE_W-1:0]  sample,
  input  logic                          scan_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          frame_close,
  output logic [pcr_pkg::PIN_W-1:0]     rec_pin,
  output logic [pcr_pkg::MODE_W-1:0]    rec_mode,
  output logic [pcr_pkg::BYTE_W-1:0]    value_high,
  output logic [pcr_pkg::BYTE_W-1:0]    value_low,
  output logic [pcr_pkg::SLOT_W-1:0]    slot,
  output logic [pcr_pkg::COUNT_W-1:0]   record_count,
  output logic                          last
);
  import pcr_pkg::*;

  logic    push;
  logic    pop;
  logic    q_full;
  logic    q_empty;
  entry_t  wr_entry;
  entry_t  head;
  result_t out_beat;

  pcr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .pin_modes_we (pin_modes_we),
    .pin_modes    (pin_modes),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pin          (pin),
    .sample       (sample),
    .scan_end     (scan_end),
    .q_full       (q_full),
    .push         (push),
    .entry        (wr_entry)
  );

  pcr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  pcr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

  assign frame_close  = out_beat.frame_close;
  assign rec_pin      = out_beat.rec_pin;
  assign rec_mode     = out_beat.rec_mode;
  assign value_high   = out_beat.value_high;
  assign value_low    = out_beat.value_low;
  assign slot         = out_beat.slot;
  assign record_count = out_beat.record_count;
  assign last         = out_beat.last;

endmodule
